// ===== hdl/alwp_pkg.sv =====
`timescale 1ns / 1ps

package alwp_pkg;

  // Default sizes of the block.
  localparam int unsigned NUM_ENTRIES_DEF = 16;
  localparam int unsigned WEIGHT_BITS_DEF = 16;
  localparam int unsigned RAND_BITS_DEF   = 24;

  // Fixed widths of the entry index and status fields.
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned STATUS_W = 2;

  // Request types.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_PICK  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_PICKED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WRITTEN = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic CFG_WEIGHTED = 1'b0;
  localparam logic CFG_DYNAMIC  = 1'b1;
  localparam logic WEIGHTED_RST = 1'b1;
  localparam logic DYNAMIC_RST  = 1'b0;

  // Control from the sequencer to the accumulate and compare unit.
  typedef struct packed {
    logic clr;
    logic acc_en;
    logic mul_en;
    logic scan_en;
  } acc_ctl_t;

  // Status back from the accumulate and compare unit.
  typedef struct packed {
    logic total_zero;
    logic hit;
  } acc_sts_t;

endpackage

// ===== hdl/alwp_ram.sv =====
`timescale 1ns / 1ps

module alwp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/alwp_acc.sv =====
`timescale 1ns / 1ps

module alwp_acc #(
  parameter int unsigned NUM_ENTRIES = alwp_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned WEIGHT_BITS = alwp_pkg::WEIGHT_BITS_DEF,
  parameter int unsigned RAND_BITS   = alwp_pkg::RAND_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  alwp_pkg::acc_ctl_t     ctl_i,
  input  logic [WEIGHT_BITS-1:0] contrib_i,
  input  logic [RAND_BITS:0]     rnum_i,
  output alwp_pkg::acc_sts_t     sts_o
);

  localparam int unsigned AW = $clog2(NUM_ENTRIES);
  localparam int unsigned TW = WEIGHT_BITS + AW;
  localparam int unsigned PW = TW + RAND_BITS + 1;

  logic [TW-1:0] total_q, total_d;
  logic [TW-1:0] cum_q, cum_d;
  logic [PW-1:0] prod_q;
  logic [PW-1:0] cum_scaled;

  assign total_d    = total_q + TW'(contrib_i);
  assign cum_d      = cum_q + TW'(contrib_i);
  assign cum_scaled = {1'b0, cum_d, {RAND_BITS{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      cum_q   <= '0;
    end else if (ctl_i.clr) begin
      total_q <= '0;
      cum_q   <= '0;
    end else begin
      if (ctl_i.acc_en) begin
        total_q <= total_d;
      end
      if (ctl_i.scan_en) begin
        cum_q <= cum_d;
      end
    end
  end

  // The product of the random numerator and the total is taken once per pick.
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= PW'(rnum_i) * PW'(total_q);
    end
  end

  assign sts_o.total_zero = (total_q == '0);
  assign sts_o.hit        = ctl_i.scan_en && (cum_scaled >= prod_q);

endmodule

// ===== hdl/adaptive_weighted_lottery_picker.sv =====
`timescale 1ns / 1ps

// Weighted lottery picker. The entry table (weight, minimum, maximum, enable) lives in one
// synchronous RAM of NUM_ENTRIES words, read one word a cycle. A write word stores one entry,
// if its index lies in the table, and goes straight to the final step. A pick word walks the
// table once to form the enabled total, forms the product of the random numerator and the
// total, then walks the table again until the first enabled entry whose cumulative weight
// reaches that share. In dynamic weighted mode the chosen weight is halved unless that takes
// it below a non-zero minimum, and if it is then 1 or below a third walk doubles every weight
// that its ceiling allows. The final step hands the result to the output register. The length
// of a pick is set by the single read port of the table RAM. One word is in work at a time;
// the next word is accepted as soon as the result sits in the output register, even while
// that result is still stalled. Table entries read as zero until first written.
// Configuration registers may only be written while no word is in work.
module adaptive_weighted_lottery_picker #(
  parameter int unsigned NUM_ENTRIES = alwp_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned WEIGHT_BITS = alwp_pkg::WEIGHT_BITS_DEF,
  parameter int unsigned RAND_BITS   = alwp_pkg::RAND_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic                            cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [alwp_pkg::IDX_W-1:0]      entry_index_i,
  input  logic [WEIGHT_BITS-1:0]          entry_weight_i,
  input  logic [WEIGHT_BITS-1:0]          entry_min_i,
  input  logic [WEIGHT_BITS-1:0]          entry_max_i,
  input  logic                            entry_enable_i,
  input  logic [RAND_BITS-1:0]            random_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [alwp_pkg::IDX_W-1:0]      chosen_index_o,
  output logic [alwp_pkg::STATUS_W-1:0]   status_o
);

  localparam int unsigned AW = $clog2(NUM_ENTRIES);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned W  = WEIGHT_BITS;
  localparam int unsigned DW = 3 * W + 1;
  localparam int unsigned IW = alwp_pkg::IDX_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TOTAL  = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_HALVE  = 3'd4;
  localparam logic [2:0] S_DOUBLE = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic weighted_q, weighted_d;
  logic dynamic_q, dynamic_d;

  // Table walk: read counter, and the tag of the word coming back from the RAM.
  logic [CW-1:0] rd_cnt_q, rd_cnt_d;
  logic          rd_pend_q;
  logic [AW-1:0] rd_tag_q;
  logic          rd_vld_q;
  logic          rd_issue;
  logic          walk_done;

  // Per-entry written flags; an entry never written reads as all zero.
  logic [NUM_ENTRIES-1:0] vld_q, vld_d;

  // Request payload and result being built.
  logic [RAND_BITS:0]            rnum_q;
  logic [AW-1:0]                 pick_idx_q;
  logic [DW-1:0]                 pick_ent_q;
  logic [IW-1:0]                 res_idx_q, res_idx_d;
  logic [alwp_pkg::STATUS_W-1:0] res_sts_q, res_sts_d;

  // Output register.
  logic                          out_valid_q, out_valid_d;
  logic [IW-1:0]                 out_idx_q;
  logic [alwp_pkg::STATUS_W-1:0] out_sts_q;
  logic                          out_load;

  // RAM port signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [DW-1:0] ram_rdata;

  // Decoded word from the RAM.
  logic [DW-1:0] ent;
  logic [W-1:0]  ent_w, ent_max;
  logic          ent_en;
  logic [W-1:0]  contrib;

  // Weight updates.
  logic [W-1:0]  pk_w, pk_min, pk_half, pk_new;
  logic [W:0]    dbl;
  logic [W-1:0]  dbl_w;

  // Write request decode.
  logic          in_acc;
  logic          wr_req;
  logic          wr_in_range;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] idx_addr_w;

  alwp_pkg::acc_ctl_t acc_ctl;
  alwp_pkg::acc_sts_t acc_sts;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wr_req     = in_acc && (req_type_i == alwp_pkg::REQ_WRITE);

  // Index conversion from the fixed 4-bit field to the table address width.
  assign wr_in_range  = (32'(entry_index_i) < 32'(NUM_ENTRIES));
  assign idx_addr_w   = AW'({{AW{1'b0}}, entry_index_i});
  assign wr_addr      = idx_addr_w;

  // Configuration writes.
  always_comb begin
    weighted_d = weighted_q;
    dynamic_d  = dynamic_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        alwp_pkg::CFG_WEIGHTED: weighted_d = cfg_data_i;
        alwp_pkg::CFG_DYNAMIC:  dynamic_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  // The RAM word as seen by the walk; unwritten entries read as zero.
  assign ent     = rd_vld_q ? ram_rdata : '0;
  assign ent_w   = ent[W-1:0];
  assign ent_max = ent[3*W-1:2*W];
  assign ent_en  = ent[3*W];
  assign contrib = ent_en ? (weighted_q ? ent_w : W'(1)) : '0;

  // Halving of the chosen entry, respecting its floor.
  assign pk_w    = pick_ent_q[W-1:0];
  assign pk_min  = pick_ent_q[2*W-1:W];
  assign pk_half = pk_w >> 1;
  assign pk_new  = ((pk_min == '0) || (pk_min <= pk_half)) ? pk_half : pk_w;

  // Doubling of the word coming back during the doubling walk, respecting its ceiling
  // and saturating at the full weight range.
  assign dbl   = {ent_w, 1'b0};
  assign dbl_w = ((ent_max == '0) || ({1'b0, ent_max} >= dbl)) ?
                 (dbl[W] ? {W{1'b1}} : dbl[W-1:0]) : ent_w;

  // A walk issues one read a cycle until every entry has been addressed.
  assign rd_issue  = ((state_q == S_TOTAL) || (state_q == S_SCAN) || (state_q == S_DOUBLE)) &&
                     (rd_cnt_q < CW'(NUM_ENTRIES));
  assign walk_done = (rd_cnt_q == CW'(NUM_ENTRIES)) && !rd_pend_q;

  assign acc_ctl.clr     = in_acc;
  assign acc_ctl.acc_en  = (state_q == S_TOTAL) && rd_pend_q;
  assign acc_ctl.mul_en  = (state_q == S_MUL);
  assign acc_ctl.scan_en = (state_q == S_SCAN) && rd_pend_q;

  // Table write port: entry load from a write word, the halved weight, or a doubled weight.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = {entry_enable_i, entry_max_i, entry_min_i, entry_weight_i};
    if (wr_req && wr_in_range) begin
      ram_we = 1'b1;
    end else if (state_q == S_HALVE) begin
      ram_we    = 1'b1;
      ram_waddr = pick_idx_q;
      ram_wdata = {pick_ent_q[3*W:W], pk_new};
    end else if ((state_q == S_DOUBLE) && rd_pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = rd_tag_q;
      ram_wdata = {ent[3*W:W], dbl_w};
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (ram_we) begin
      vld_d[ram_waddr] = 1'b1;
    end
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    rd_cnt_d  = rd_issue ? rd_cnt_q + CW'(1) : rd_cnt_q;
    res_idx_d = res_idx_q;
    res_sts_d = res_sts_q;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        rd_cnt_d = '0;
        if (in_acc) begin
          res_idx_d = '0;
          if (req_type_i == alwp_pkg::REQ_WRITE) begin
            res_sts_d = alwp_pkg::ST_WRITTEN;
            state_d   = S_DONE;
          end else begin
            state_d = S_TOTAL;
          end
        end
      end
      S_TOTAL: begin
        if (walk_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        rd_cnt_d = '0;
        if (acc_sts.total_zero) begin
          res_sts_d = alwp_pkg::ST_EMPTY;
          state_d   = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (acc_ctl.scan_en && ent_en && acc_sts.hit) begin
          res_idx_d = IW'({{IW{1'b0}}, rd_tag_q});
          res_sts_d = alwp_pkg::ST_PICKED;
          state_d   = (weighted_q && dynamic_q) ? S_HALVE : S_DONE;
        end else if (walk_done) begin
          // Cannot happen with a non-zero total; reported as empty for safety.
          res_sts_d = alwp_pkg::ST_EMPTY;
          state_d   = S_DONE;
        end
      end
      S_HALVE: begin
        rd_cnt_d = '0;
        state_d  = (pk_new <= W'(1)) ? S_DOUBLE : S_DONE;
      end
      S_DOUBLE: begin
        if (walk_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      weighted_q  <= alwp_pkg::WEIGHTED_RST;
      dynamic_q   <= alwp_pkg::DYNAMIC_RST;
      rd_cnt_q    <= '0;
      rd_pend_q   <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      weighted_q  <= weighted_d;
      dynamic_q   <= dynamic_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_pend_q   <= rd_issue;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    res_idx_q <= res_idx_d;
    res_sts_q <= res_sts_d;
    if (rd_issue) begin
      rd_tag_q <= rd_cnt_q[AW-1:0];
      rd_vld_q <= vld_q[rd_cnt_q[AW-1:0]];
    end
    if (in_acc) begin
      rnum_q <= {1'b0, random_value_i} + (RAND_BITS + 1)'(1);
    end
    if ((state_q == S_SCAN) && acc_ctl.scan_en && ent_en && acc_sts.hit) begin
      pick_idx_q <= rd_tag_q;
      pick_ent_q <= ent;
    end
    if (out_load) begin
      out_idx_q <= res_idx_q;
      out_sts_q <= res_sts_q;
    end
  end

  alwp_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_issue),
    .raddr_i (rd_cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  alwp_acc #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS),
    .RAND_BITS   (RAND_BITS)
  ) u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (acc_ctl),
    .contrib_i (contrib),
    .rnum_i    (rnum_q),
    .sts_o     (acc_sts)
  );

  assign out_valid_o    = out_valid_q;
  assign chosen_index_o = out_idx_q;
  assign status_o       = out_sts_q;

  // The totalling and selection walks only read the table; a write there would corrupt
  // the sums being formed.
  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_TOTAL) || (state_q == S_SCAN) || (state_q == S_MUL)) |-> !ram_we)
    else $error("table written during a read-only walk");

  // The read counter never runs past the end of the table.
  a_rd_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_cnt_q <= CW'(NUM_ENTRIES))
    else $error("table read counter overran");

  // Weight adjustment only happens in dynamic weighted mode.
  a_halve_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HALVE) |-> (weighted_q && dynamic_q))
    else $error("weight halved outside dynamic weighted mode");

  // Every accepted word puts the sequencer to work, and a result is only loaded from
  // the final step.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("accepted word did not start work");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q == S_DONE))
    else $error("result loaded outside the final step");

endmodule
